/* rtl/move_to_front_rank_assert.svh */
// Assertion macros used by the checker module.
`ifndef MOVE_TO_FRONT_RANK_ASSERT_SVH
`define MOVE_TO_FRONT_RANK_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define MTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define MTF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mtf_pkg.sv */
package mtf_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int COUNT_W   = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [PADDR_W-1:0] ADDR_ITEM_COUNT = 3'd0;
  localparam logic [COUNT_W-1:0] ITEM_COUNT_RST  = 9'd256;

  typedef struct packed {
    logic       new_case;
    logic [7:0] item;
  } in_data_t;

  typedef struct packed {
    logic [7:0] rank;
    logic       error;
  } out_data_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic issue;
    logic proc;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;
    logic match;
  } status_t;

endpackage

/* rtl/mtf_datapath.sv */
module mtf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mtf_pkg::cmd_t                  cmd,
  input  mtf_pkg::in_data_t              in_data,
  input  logic [mtf_pkg::COUNT_W-1:0]    item_count,
  output mtf_pkg::status_t               status,
  output mtf_pkg::out_data_t             out_data
);
  import mtf_pkg::*;

  logic [7:0]             mem [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]   valid_r;
  logic [7:0]             rd_data_r;
  logic                   rd_valid_r;
  logic [ADDR_W-1:0]      rd_addr_r;
  logic [ADDR_W-1:0]      rd_cnt_r;
  logic [7:0]             item_r;
  logic [7:0]             carry_r;
  logic [7:0]             rank_r;
  logic                   err_r;
  out_data_t              out_data_r;
  logic [7:0]             entry;
  logic                   err_now;

  // Bad id check against the programmed count
  assign err_now = ({1'b0, in_data.item} >= item_count);

  // An entry never written since the last restore holds its own depth
  assign entry = rd_valid_r ? rd_data_r : rd_addr_r;

  assign status.err   = err_r;
  assign status.match = (entry == item_r);

  // Stack memory: one read and one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.proc) begin
      mem[rd_addr_r] <= carry_r;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_cnt_r];
    end
  end

  // Written flags, dropped at once by a restore
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.start && in_data.new_case) begin
      valid_r <= '0;
    end else if (cmd.proc) begin
      valid_r[rd_addr_r] <= 1'b1;
    end
  end

  // Scan pointer and read tracking
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_cnt_r <= '0;
    end else if (cmd.issue) begin
      rd_cnt_r   <= rd_cnt_r + 1'b1;
      rd_valid_r <= valid_r[rd_cnt_r];
      rd_addr_r  <= rd_cnt_r;
    end
  end

  // Capture item, shift the carried entry down, record the depth on match
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r  <= in_data.item;
      carry_r <= in_data.item;
      err_r   <= err_now;
      rank_r  <= '0;
    end else if (cmd.proc) begin
      carry_r <= entry;
      if (status.match) begin
        rank_r <= rd_addr_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.rank  <= rank_r;
      out_data_r.error <= err_r;
    end
  end

  assign out_data = out_data_r;

endmodule

/* rtl/mtf_ctrl.sv */
module mtf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mtf_pkg::status_t  status,
  output mtf_pkg::cmd_t     cmd
);
  import mtf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (status.err) begin
          state_nxt = S_FIN;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        cmd.proc  = 1'b1;
        if (status.match) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/move_to_front_rank.sv */
// Move-to-front rank: an accepted item goes through FIRST, then SCAN down to its depth
// (skipped for a bad id), then FIN (depth = items above the accessed one, 0..255).
// One item at a time: a new item is taken only once the last result is loaded; the
// scan reads one stack entry per cycle, and a stalled earlier result adds its wait.
// Synchronous active-low reset restores the initial order (written flags clear)
// and sets item_count to 256; a new_case item restores it too, as it is accepted.
module move_to_front_rank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mtf_pkg::in_data_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mtf_pkg::out_data_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtf_pkg::PADDR_W-1:0]   paddr,
  input  logic [mtf_pkg::PDATA_W-1:0]   pwdata,
  output logic [mtf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mtf_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [COUNT_W-1:0] item_count_r;

  assign pready = 1'b1;

  // Configuration register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= ITEM_COUNT_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_ITEM_COUNT) begin
      item_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ITEM_COUNT) begin
      prdata = {{(PDATA_W-COUNT_W){1'b0}}, item_count_r};
    end
  end

  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mtf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .item_count (item_count_r),
    .status     (status),
    .out_data   (out_data)
  );

endmodule

/* rtl/mtf_checker.sv */
`include "move_to_front_rank_assert.svh"

module mtf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mtf_pkg::out_data_t            out_data,
  input  logic                          pready
);
  import mtf_pkg::*;

  logic out_wait;

  assign out_wait = out_valid && out_stall;

  // Hold a stalled result
  `MTF_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_data), "stalled result moved")

  // Drop any result after reset
  `MTF_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid right after reset")

  // A bad id always reports rank zero
  `MTF_ASSERT(a_err_rank, out_valid && out_data.error |-> out_data.rank == '0, "bad id rank")

  // One item at a time: stall right after an accept
  `MTF_ASSERT(a_busy, in_valid && !in_stall |=> in_stall, "second item taken while busy")

  // Keep the config port always ready
  `MTF_ASSERT(a_pready, pready, "pready low")

endmodule

bind move_to_front_rank mtf_checker u_chk (.*);
